/* rtl/jls_pkg.sv */
// Shared types, codes and constants of the Jacobi Laplace grid solver.
package jls_pkg;

  localparam int SIDE_W     = 7;
  localparam int IDX_W      = 6;
  localparam int VAL_W      = 23;
  localparam int SWEEP_W    = 16;
  localparam int SUM_W      = VAL_W + 2;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam int                   DEF_MAX_SIDE    = 64;
  localparam logic [SIDE_W-1:0]    DEF_GRID_SIDE   = 7'd64;
  localparam logic [SWEEP_W-1:0]   DEF_SWEEP_COUNT = 16'd3001;
  localparam logic [VAL_W-1:0]     VAL_MAX         = 23'd6553600;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_SOLVE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic {
    REG_GRID_SIDE   = 1'b0,
    REG_SWEEP_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_SWEEP_END,
    ST_COPY,
    ST_COPY_END,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] column;
    logic [VAL_W-1:0] cell_value;
  } jls_cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] cell_value_res;
    logic             solve_done;
  } jls_rsp_t;

  typedef struct packed {
    logic              idle;
    logic              rd_ns;
    logic              rd_we;
    logic              cp_rd;
    logic              fin;
    logic [SIDE_W-1:0] row;
    logic [SIDE_W-1:0] col;
  } seq_ctl_t;

endpackage

/* rtl/jls_stream_if.sv */
// Valid/ready stream channel carrying one payload per transaction.
interface jls_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/jls_sweep_seq.sv */
// Solve sequencer: walks the interior cells for each sweep and copy pass.
module jls_sweep_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [jls_pkg::SIDE_W-1:0]     side,
  input  logic [jls_pkg::SWEEP_W-1:0]    sweeps,
  input  logic                           fin_ack,
  output jls_pkg::seq_ctl_t              ctl
);
  import jls_pkg::*;

  seq_state_t         state, state_next;
  logic [SIDE_W-1:0]  row, row_next;
  logic [SIDE_W-1:0]  col, col_next;
  logic [SWEEP_W-1:0] swept, swept_next;
  logic               phase, phase_next;
  logic [SIDE_W-1:0]  inner_max;
  logic               last_col, last_row, last_cell, no_work;
  logic [SWEEP_W-1:0] swept_inc;

  assign inner_max = side - SIDE_W'(2);
  assign last_col  = (col == inner_max);
  assign last_row  = (row == inner_max);
  assign last_cell = last_col && last_row;
  assign no_work   = (side < SIDE_W'(3)) || (sweeps == '0);
  assign swept_inc = swept + SWEEP_W'(1);

  always_comb begin
    state_next = state;
    row_next   = row;
    col_next   = col;
    swept_next = swept;
    phase_next = phase;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          row_next   = SIDE_W'(1);
          col_next   = SIDE_W'(1);
          phase_next = 1'b0;
          swept_next = '0;
          state_next = no_work ? ST_FINISH : ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        phase_next = ~phase;
        if (phase) begin
          if (last_col) begin
            col_next = SIDE_W'(1);
            row_next = last_row ? SIDE_W'(1) : row + SIDE_W'(1);
          end else begin
            col_next = col + SIDE_W'(1);
          end
          if (last_cell) begin
            state_next = ST_SWEEP_END;
          end
        end
      end
      ST_SWEEP_END: begin
        state_next = ST_COPY;
      end
      ST_COPY: begin
        if (last_col) begin
          col_next = SIDE_W'(1);
          row_next = last_row ? SIDE_W'(1) : row + SIDE_W'(1);
        end else begin
          col_next = col + SIDE_W'(1);
        end
        if (last_cell) begin
          state_next = ST_COPY_END;
        end
      end
      ST_COPY_END: begin
        swept_next = swept_inc;
        state_next = (swept_inc == sweeps) ? ST_FINISH : ST_SWEEP;
      end
      ST_FINISH: begin
        if (fin_ack) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl       = '0;
    ctl.idle  = (state == ST_IDLE);
    ctl.rd_ns = (state == ST_SWEEP) && !phase;
    ctl.rd_we = (state == ST_SWEEP) && phase;
    ctl.cp_rd = (state == ST_COPY);
    ctl.fin   = (state == ST_FINISH);
    ctl.row   = row;
    ctl.col   = col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row   <= '0;
      col   <= '0;
      swept <= '0;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
      swept <= swept_next;
      phase <= phase_next;
    end
  end

endmodule

/* rtl/jacobi_laplace_grid_solver_unit.sv */
// Jacobi Laplace grid solver: grid memories, command decode, sweep datapath, result queue.
// Write transactions go straight to the current grid; a read transaction's data is registered
// and then enters the result queue, and reads and writes are accepted back to back at one per
// cycle while the result queue has room. A solve transaction runs sweep_count sweeps over
// I = (side-2)^2 interior cells: each cell is read from the current grid as a north/south pair
// then a west/east pair, bound by the current-grid read ports, and later copied back; each
// pass ends in a drain state. With a side below 3 or no sweeps the sequencer finishes at once.
// Reset clears control and sets grid_side to 64 and sweep_count to 3001; the grid contents
// stay undefined until written, and no clearing pass runs.
module jacobi_laplace_grid_solver_unit #(
  parameter int MAX_SIDE = jls_pkg::DEF_MAX_SIDE
) (
  input  logic                             clk,
  input  logic                             rst,
  jls_stream_if.sink                       cmd,
  jls_stream_if.source                     rsp,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [jls_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [jls_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [jls_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import jls_pkg::*;

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);

  // Config registers: the user writes them over APB while the block is idle; unchecked.
  logic [SIDE_W-1:0]  grid_side;
  logic [SWEEP_W-1:0] sweep_count;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  // Command decode.
  logic               cmd_acc, cmd_inside, cmd_wr, cmd_rd, start;
  logic [AW-1:0]      cmd_addr;
  logic [VAL_W-1:0]   wr_val;
  logic [SIDE_W-1:0]  side_eff;

  // Sequencer control.
  seq_ctl_t           ctl;
  logic               fin_ack;

  // Grid memories: the current grid has two read ports, the sweep buffer one.
  logic [VAL_W-1:0]   cur_mem [0:DEPTH-1];
  logic [VAL_W-1:0]   nxt_mem [0:DEPTH-1];
  logic [AW-1:0]      raddr_a, raddr_b, cur_waddr, nxt_raddr;
  logic [VAL_W-1:0]   rdata_a, rdata_b, nrdata, cur_wdata;
  logic               cur_we;

  // Sweep and copy pipeline.
  logic               ns_v, we_v, cp_v;
  logic [VAL_W:0]     ns_sum;
  logic [SUM_W-1:0]   sweep_sum;
  logic [VAL_W-1:0]   sweep_val;
  logic [AW-1:0]      sw_addr, cp_addr;

  // Result queue of two entries.
  jls_rsp_t           rsp_q [0:1];
  logic               wp, rp;
  logic [1:0]         cnt;
  logic               pop, push, fin_push, rd_pend, rd_zero;
  jls_rsp_t           push_data;
  logic [2:0]         occ;

  function automatic logic [AW-1:0] cell_addr(input logic [SIDE_W-1:0] r,
                                              input logic [SIDE_W-1:0] c);
    return AW'(int'(r) * MAX_SIDE + int'(c));
  endfunction

  // ---------------------------------------------------------------------------------------
  // Configuration port. Register i sits at byte address 4*i, so paddr[2] picks it.
  // ---------------------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side   <= DEF_GRID_SIDE;
      sweep_count <= DEF_SWEEP_COUNT;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GRID_SIDE:   grid_side   <= pwdata[SIDE_W-1:0];
        REG_SWEEP_COUNT: sweep_count <= pwdata[SWEEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_GRID_SIDE:   prdata = APB_DATA_W'(grid_side);
      REG_SWEEP_COUNT: prdata = APB_DATA_W'(sweep_count);
      default:         prdata = '0;
    endcase
  end

  // A side beyond the memory's extent is worked as the full memory side.
  assign side_eff = (int'(grid_side) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : grid_side;

  // ---------------------------------------------------------------------------------------
  // Command transactions. Writes and reads go straight to the current grid; a cell index
  // beyond the memory is dropped on write and reads back as zero. Kind 3 is swallowed.
  // ---------------------------------------------------------------------------------------
  assign cmd_acc    = cmd.valid && cmd.ready;
  assign cmd_inside = (int'(cmd.payload.row) < MAX_SIDE) &&
                      (int'(cmd.payload.column) < MAX_SIDE);
  assign cmd_addr   = cmd_inside ? cell_addr(SIDE_W'(cmd.payload.row),
                                             SIDE_W'(cmd.payload.column)) : '0;
  assign cmd_wr     = cmd_acc && (cmd.payload.kind == KIND_WRITE) && cmd_inside;
  assign cmd_rd     = cmd_acc && (cmd.payload.kind == KIND_READ);
  assign start      = cmd_acc && (cmd.payload.kind == KIND_SOLVE);
  assign wr_val     = (cmd.payload.cell_value > VAL_MAX) ? VAL_MAX : cmd.payload.cell_value;

  // New commands are taken only while no solve runs, and only if the queue can still hold
  // the result of a read accepted now, counting a read whose data is in flight.
  assign occ        = 3'({1'b0, cnt}) + 3'(rd_pend) - 3'(pop);
  assign cmd.ready  = ctl.idle && (occ <= 3'd1);

  jls_sweep_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .side    (side_eff),
    .sweeps  (sweep_count),
    .fin_ack (fin_ack),
    .ctl     (ctl)
  );

  // ---------------------------------------------------------------------------------------
  // Current grid. During a sweep each interior cell is read in two phases: north and south
  // in the first, west and east in the second. Otherwise port A serves read
  // transactions. The write port takes write transactions or the copy pass, which never
  // overlap since commands are held off during a solve.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    raddr_a = cmd_addr;
    raddr_b = cmd_addr;
    priority if (ctl.rd_ns) begin
      raddr_a = cell_addr(ctl.row - SIDE_W'(1), ctl.col);
      raddr_b = cell_addr(ctl.row + SIDE_W'(1), ctl.col);
    end else if (ctl.rd_we) begin
      raddr_a = cell_addr(ctl.row, ctl.col - SIDE_W'(1));
      raddr_b = cell_addr(ctl.row, ctl.col + SIDE_W'(1));
    end
  end

  assign cur_we    = cmd_wr || cp_v;
  assign cur_waddr = cp_v ? cp_addr : cmd_addr;
  assign cur_wdata = cp_v ? nrdata : wr_val;

  always_ff @(posedge clk) begin
    rdata_a <= cur_mem[raddr_a];
    rdata_b <= cur_mem[raddr_b];
    if (cur_we) begin
      cur_mem[cur_waddr] <= cur_wdata;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sweep datapath. The north/south pair is summed when it returns; in the next cycle the
  // west/east pair completes the sum, and the quarter goes to the sweep buffer. Only the
  // sweep buffer is written during a sweep, so all neighbor reads see the previous sweep.
  // ---------------------------------------------------------------------------------------
  assign sweep_sum = SUM_W'(ns_sum) + SUM_W'(rdata_a) + SUM_W'(rdata_b);
  assign sweep_val = sweep_sum[SUM_W-1:2];
  assign nxt_raddr = cell_addr(ctl.row, ctl.col);

  always_ff @(posedge clk) begin
    nrdata <= nxt_mem[nxt_raddr];
    if (we_v) begin
      nxt_mem[sw_addr] <= sweep_val;
    end
  end

  always_ff @(posedge clk) begin
    if (ns_v) begin
      ns_sum <= {1'b0, rdata_a} + {1'b0, rdata_b};
    end
    if (ctl.rd_we) begin
      sw_addr <= cell_addr(ctl.row, ctl.col);
    end
    if (ctl.cp_rd) begin
      cp_addr <= nxt_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ns_v    <= 1'b0;
      we_v    <= 1'b0;
      cp_v    <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      ns_v    <= ctl.rd_ns;
      we_v    <= ctl.rd_we;
      cp_v    <= ctl.cp_rd;
      rd_pend <= cmd_rd;
    end
  end

  always_ff @(posedge clk) begin
    rd_zero <= !cmd_inside;
  end

  // ---------------------------------------------------------------------------------------
  // Result queue. Read data enters the cycle after the read; the solve completion enters
  // when the sequencer finishes and there is room. A stalled consumer never blocks the
  // acceptance of a read as long as one entry remains.
  // ---------------------------------------------------------------------------------------
  assign pop      = rsp.valid && rsp.ready;
  assign fin_push = ctl.fin && !rd_pend && ((cnt != 2'd2) || pop);
  assign fin_ack  = fin_push;
  assign push     = rd_pend || fin_push;

  always_comb begin
    push_data = '0;
    if (rd_pend) begin
      push_data.cell_value_res = rd_zero ? '0 : rdata_a;
      push_data.solve_done     = 1'b0;
    end else begin
      push_data.cell_value_res = '0;
      push_data.solve_done     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rsp_q[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  assign rsp.valid   = (cnt != 2'd0);
  assign rsp.payload = rsp_q[rp];

  // ---------------------------------------------------------------------------------------
  // Checks on the ordering of grid accesses and on the result queue.
  // ---------------------------------------------------------------------------------------
  a_sweep_drained_before_copy: assert property (@(posedge clk) disable iff (rst)
    ctl.cp_rd |-> !we_v)
    else $error("copy pass reads the sweep buffer while a sweep write is pending");

  a_copy_drained_before_sweep: assert property (@(posedge clk) disable iff (rst)
    ctl.rd_ns |-> !cp_v)
    else $error("sweep reads the current grid while a copy write is pending");

  a_no_cmd_write_during_copy: assert property (@(posedge clk) disable iff (rst)
    cp_v |-> !cmd_wr)
    else $error("write transaction collides with the copy pass");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !pop) |-> !push)
    else $error("result queue overflow");

  a_single_push_source: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !fin_push)
    else $error("read data and solve completion pushed in the same cycle");

endmodule
